@@ rtl/tpd_pkg.sv @@
package tpd_pkg;

    // sensor lanes built; lanes past the input fields see an absent sensor
    localparam int SENSOR_COUNT  = 4;
    localparam int FIELD_SENSORS = 4;

    localparam int RANGE_W = 16;
    localparam int MASK_W  = 4;
    localparam int LIMIT_W = 4;
    localparam int COUNT_W = 5;

    localparam logic [RANGE_W-1:0] NO_RANGE  = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    // stream widths
    localparam int IN_DATA_W  = 2 * MASK_W + FIELD_SENSORS * RANGE_W;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 2 * FIELD_SENSORS * RANGE_W;
    localparam int OUT_USER_W = 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_THR_NORMAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_FIRST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_POS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_EN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEB_LIMIT  = 3'd5;

    localparam logic [RANGE_W-1:0] THR_NORMAL_RST = 16'd380;
    localparam logic [RANGE_W-1:0] THR_FIRST_RST  = 16'd300;
    localparam logic [LIMIT_W-1:0] DEB_LIMIT_RST  = 4'd5;

    // round control shared by all lanes
    typedef struct packed {
        logic                update;
        logic                blank;
        logic [RANGE_W-1:0]  threshold;
    } t_lane_ctrl;

    // flags and events out of the merge stage
    typedef struct packed {
        logic occupied_event;
        logic installed_event;
        logic installed_now;
        logic occupied;
    } t_flags;

endpackage

@@ rtl/tpd_lane.sv @@
module tpd_lane
    import tpd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_lane_ctrl          i_ctrl,
    input  logic                i_present,
    input  logic                i_ok,
    input  logic [RANGE_W-1:0]  i_range,
    output logic [RANGE_W-1:0]  o_next_stored,
    output logic [RANGE_W-1:0]  o_next_least,
    output logic                o_seen
);

    logic [RANGE_W-1:0] r_stored, n_stored;
    logic [RANGE_W-1:0] r_least,  n_least;
    logic               w_good;

    assign w_good = i_present && i_ok && !i_ctrl.blank;

    // next distance and minimum for this round
    always_comb begin
        n_stored = r_stored;
        n_least  = r_least;
        if (i_ctrl.update) begin
            if (i_ctrl.blank) begin
                n_stored = NO_RANGE;
            end else if (i_present) begin
                if (i_ok) begin
                    n_stored = i_range;
                    if (i_range < r_least) begin
                        n_least = i_range;
                    end
                end else begin
                    n_stored = NO_RANGE;
                end
            end
        end
    end

    // good reading inside the occupancy window
    assign o_seen = w_good && (i_range != NO_RANGE) && (i_range != '0)
                    && (i_range < i_ctrl.threshold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored <= NO_RANGE;
            r_least  <= NO_RANGE;
        end else begin
            r_stored <= n_stored;
            r_least  <= n_least;
        end
    end

    assign o_next_stored = n_stored;
    assign o_next_least  = n_least;

endmodule

@@ rtl/tpd_merge.sv @@
module tpd_merge
    import tpd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_update,
    input  logic                     i_tray,
    input  logic                     i_layer_en,
    input  logic [LIMIT_W-1:0]       i_limit,
    input  logic [SENSOR_COUNT-1:0]  i_seen,
    output t_flags                   o_flags
);

    logic               r_occupied,  n_occupied;
    logic               r_installed, n_installed;
    logic [COUNT_W-1:0] r_count,     n_count;
    logic [COUNT_W-1:0] w_count_inc;
    logic               w_seen;
    logic               w_mismatch;
    logic               w_inst_ev, w_occ_ev;

    // combine the lanes
    assign w_seen      = |i_seen;
    assign w_mismatch  = (w_seen != r_occupied);
    assign w_count_inc = (r_count < COUNT_MAX) ? r_count + 1'b1 : r_count;

    // advance installed flag, occupied flag and debounce counter
    always_comb begin
        n_occupied  = r_occupied;
        n_installed = r_installed;
        n_count     = r_count;
        w_inst_ev   = 1'b0;
        w_occ_ev    = 1'b0;
        if (i_update) begin
            n_installed = i_tray;
            w_inst_ev   = (i_tray != r_installed);
            if (i_tray && i_layer_en) begin
                if (w_mismatch) begin
                    n_count = w_count_inc;
                    if (w_count_inc > {1'b0, i_limit}) begin
                        n_occupied = w_seen;
                        n_count    = '0;
                        w_occ_ev   = 1'b1;
                    end
                end else begin
                    n_count = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occupied  <= 1'b0;
            r_installed <= 1'b0;
            r_count     <= '0;
        end else begin
            r_occupied  <= n_occupied;
            r_installed <= n_installed;
            r_count     <= n_count;
        end
    end

    assign o_flags.occupied        = n_occupied;
    assign o_flags.installed_now   = n_installed;
    assign o_flags.installed_event = w_inst_ev;
    assign o_flags.occupied_event  = w_occ_ev;

endmodule

@@ rtl/tray_presence_debouncer.sv @@
// An accepted request's result is registered in the output register, or in the skid
// entry while the master holds the output; throughput is one request per cycle while
// the skid entry is empty. All sensor lanes and the debounce merge settle in the cycle
// of acceptance, and a two-entry output buffer holds results.
// Reset (i_rst_n low, synchronous): distances and minima read 0xFFFF, flags and
// counter clear, configuration returns to its defaults, output buffer empties.
module tray_presence_debouncer
    import tpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // tdata: sensor_present_mask, read_ok_mask, range_a, range_b, range_c, range_d
    input  logic [IN_DATA_W-1:0]   i_s_tdata,
    // tuser: tray_installed
    input  logic [IN_USER_W-1:0]   i_s_tuser,
    // master side
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // tdata: shown_a, shown_b, shown_c, shown_d, least_a, least_b, least_c, least_d
    output logic [OUT_DATA_W-1:0]  o_m_tdata,
    // tuser: occupied, installed_now, installed_event, occupied_event
    output logic [OUT_USER_W-1:0]  o_m_tuser,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [RANGE_W-1:0]   r_thr_normal;
    logic [RANGE_W-1:0]   r_thr_first;
    logic                 r_first_pos;
    logic                 r_layer_en;
    logic                 r_calib;
    logic [LIMIT_W-1:0]   r_limit;

    logic                 w_accept;
    logic                 w_tray;
    t_lane_ctrl           w_ctrl;
    t_flags               w_flags;

    logic [RANGE_W-1:0]      w_next_stored [SENSOR_COUNT];
    logic [RANGE_W-1:0]      w_next_least  [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] w_seen;

    logic [OUT_DATA_W-1:0]   w_res_data;
    logic [OUT_USER_W-1:0]   w_res_user;

    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;
    logic [OUT_USER_W-1:0]   r_out_user;
    logic                    r_skid_valid;
    logic [OUT_DATA_W-1:0]   r_skid_data;
    logic [OUT_USER_W-1:0]   r_skid_user;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_normal <= THR_NORMAL_RST;
            r_thr_first  <= THR_FIRST_RST;
            r_first_pos  <= 1'b0;
            r_layer_en   <= 1'b0;
            r_calib      <= 1'b0;
            r_limit      <= DEB_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_THR_NORMAL: r_thr_normal <= i_cfg_data[RANGE_W-1:0];
                REG_THR_FIRST:  r_thr_first  <= i_cfg_data[RANGE_W-1:0];
                REG_FIRST_POS:  r_first_pos  <= i_cfg_data[0];
                REG_LAYER_EN:   r_layer_en   <= i_cfg_data[0];
                REG_CALIB:      r_calib      <= i_cfg_data[0];
                REG_DEB_LIMIT:  r_limit      <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // round control
    assign o_s_tready       = !r_skid_valid;
    assign w_accept         = i_s_tvalid && o_s_tready;
    assign w_tray           = i_s_tuser[0];
    assign w_ctrl.update    = w_accept && !r_calib;
    assign w_ctrl.blank     = !w_tray || !r_layer_en;
    assign w_ctrl.threshold = r_first_pos ? r_thr_first : r_thr_normal;

    // sensor lanes
    for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
        logic               w_present;
        logic               w_ok;
        logic [RANGE_W-1:0] w_range;

        if (i < FIELD_SENSORS) begin : g_field
            assign w_present = i_s_tdata[i];
            assign w_ok      = i_s_tdata[MASK_W + i];
            assign w_range   = i_s_tdata[2*MASK_W + RANGE_W*i +: RANGE_W];
        end else begin : g_absent
            assign w_present = 1'b0;
            assign w_ok      = 1'b0;
            assign w_range   = NO_RANGE;
        end

        tpd_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_present     (w_present),
            .i_ok          (w_ok),
            .i_range       (w_range),
            .o_next_stored (w_next_stored[i]),
            .o_next_least  (w_next_least[i]),
            .o_seen        (w_seen[i])
        );
    end

    // merge lane findings into the debounced flags
    tpd_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_update   (w_ctrl.update),
        .i_tray     (w_tray),
        .i_layer_en (r_layer_en),
        .i_limit    (r_limit),
        .i_seen     (w_seen),
        .o_flags    (w_flags)
    );

    // pack the result
    for (genvar i = 0; i < FIELD_SENSORS; i++) begin : g_pack
        if (i < SENSOR_COUNT) begin : g_real
            assign w_res_data[RANGE_W*i +: RANGE_W] = w_next_stored[i];
            assign w_res_data[RANGE_W*(FIELD_SENSORS+i) +: RANGE_W] = w_next_least[i];
        end else begin : g_none
            assign w_res_data[RANGE_W*i +: RANGE_W] = NO_RANGE;
            assign w_res_data[RANGE_W*(FIELD_SENSORS+i) +: RANGE_W] = NO_RANGE;
        end
    end

    assign w_res_user = w_flags;

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || i_m_tready) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= w_accept;
                end
            end else if (w_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // hold payloads
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end else if (w_accept) begin
                r_out_data <= w_res_data;
                r_out_user <= w_res_user;
            end
        end else if (w_accept) begin
            r_skid_data <= w_res_data;
            r_skid_user <= w_res_user;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

@@ rtl/tpd_checker.sv @@
module tpd_checker
    import tpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   o_s_tready,
    input  logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_DATA_W-1:0]  o_m_tdata,
    input  logic [OUT_USER_W-1:0]  o_m_tuser
);

    // empty output after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // back-pressure only when a result is already waiting
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no result pending");

    // an occupancy flip needs an installed tray
    a_occ_event_installed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[3]) |-> o_m_tuser[1])
        else $error("occupancy event while tray absent");

    // stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind tray_presence_debouncer tpd_checker u_tpd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

@@ tb/tray_presence_debouncer_tb.sv @@
`timescale 1ns / 100ps

module tray_presence_debouncer_tb;
    import tpd_pkg::*;

    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int ROUNDS_PER_PHASE = 103;
    localparam int PHASE_COUNT      = 6;

    // one polling round as it enters the slave side
    typedef struct packed {
        logic                                tray_in;
        logic [MASK_W-1:0]                   present;
        logic [MASK_W-1:0]                   read_ok;
        logic [FIELD_SENSORS-1:0][RANGE_W-1:0] ranges;
    } t_round;

    // one result as it leaves the master side
    typedef struct packed {
        logic [FIELD_SENSORS-1:0][RANGE_W-1:0] shown;
        logic [FIELD_SENSORS-1:0][RANGE_W-1:0] least;
        logic                                occupied;
        logic                                installed_now;
        logic                                installed_event;
        logic                                occupied_event;
    } t_report;

    // full register set of the block
    typedef struct packed {
        logic [RANGE_W-1:0] thr_normal;
        logic [RANGE_W-1:0] thr_first;
        logic               first_pos;
        logic               layer_en;
        logic               calib;
        logic [LIMIT_W-1:0] deb_limit;
    } t_cfg;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic [IN_USER_W-1:0]  i_s_tuser   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [OUT_USER_W-1:0] o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // shadow of the block: registers and per-round state
    t_cfg                                model_cfg;
    logic [FIELD_SENSORS-1:0][RANGE_W-1:0] stored_dist;
    logic [FIELD_SENSORS-1:0][RANGE_W-1:0] least_dist;
    logic                                occ_flag;
    logic                                inst_flag;
    logic [COUNT_W-1:0]                  miss_count;

    t_report pending_reports[$];
    int      fail_count   = 0;
    int      quiet_cycles = 0;
    int      tx_idle_pct  = 0;
    int      rx_idle_pct  = 0;

    tray_presence_debouncer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // advance the shadow state by one round and return the result it shows
    function automatic t_report next_report(input t_round r);
        t_report            rep;
        logic               seen;
        logic [RANGE_W-1:0] thr;
        int                 i;
        rep.installed_event = 1'b0;
        rep.occupied_event  = 1'b0;
        if (!model_cfg.calib) begin
            if (r.tray_in) begin
                if (!inst_flag) begin
                    inst_flag           = 1'b1;
                    rep.installed_event = 1'b1;
                end
                if (!model_cfg.layer_en) begin
                    stored_dist = {FIELD_SENSORS{NO_RANGE}};
                end else begin
                    seen = 1'b0;
                    thr  = model_cfg.first_pos ? model_cfg.thr_first : model_cfg.thr_normal;
                    for (i = 0; i < FIELD_SENSORS; i++) begin
                        if (r.present[i]) begin
                            if (!r.read_ok[i]) begin
                                stored_dist[i] = NO_RANGE;
                            end else begin
                                stored_dist[i] = r.ranges[i];
                                if (r.ranges[i] < least_dist[i])
                                    least_dist[i] = r.ranges[i];
                                if (r.ranges[i] != NO_RANGE && r.ranges[i] != '0
                                        && r.ranges[i] < thr)
                                    seen = 1'b1;
                            end
                        end
                    end
                    // count mismatching rounds, flip once past the limit
                    if (seen != occ_flag) begin
                        if (miss_count < COUNT_MAX)
                            miss_count++;
                    end else begin
                        miss_count = '0;
                    end
                    if (seen != occ_flag && miss_count > model_cfg.deb_limit) begin
                        occ_flag           = seen;
                        miss_count         = '0;
                        rep.occupied_event = 1'b1;
                    end
                end
            end else begin
                if (inst_flag) begin
                    inst_flag           = 1'b0;
                    rep.installed_event = 1'b1;
                end
                stored_dist = {FIELD_SENSORS{NO_RANGE}};
            end
        end
        rep.shown         = stored_dist;
        rep.least         = least_dist;
        rep.occupied      = occ_flag;
        rep.installed_now = inst_flag;
        return rep;
    endfunction

    function automatic t_round make_round(input logic tray, input logic [MASK_W-1:0] present,
                                          input logic [MASK_W-1:0] ok,
                                          input logic [RANGE_W-1:0] a, input logic [RANGE_W-1:0] b,
                                          input logic [RANGE_W-1:0] c, input logic [RANGE_W-1:0] d);
        t_round r;
        r.tray_in = tray;
        r.present = present;
        r.read_ok = ok;
        r.ranges  = {d, c, b, a};
        return r;
    endfunction

    // random round that mostly leans toward the wanted occupancy
    function automatic t_round random_round(input logic want_occ);
        t_round             r;
        logic [RANGE_W-1:0] thr;
        int                 i;
        thr       = model_cfg.first_pos ? model_cfg.thr_first : model_cfg.thr_normal;
        r.tray_in = ($urandom_range(0, 19) != 0);
        r.present = ($urandom_range(0, 3) == 0) ? MASK_W'($urandom_range(0, 15)) : '1;
        r.read_ok = ($urandom_range(0, 3) == 0) ? MASK_W'($urandom_range(0, 15)) : '1;
        for (i = 0; i < FIELD_SENSORS; i++) begin
            case ($urandom_range(0, 9))
                0: r.ranges[i] = '0;
                1: r.ranges[i] = NO_RANGE;
                2: r.ranges[i] = RANGE_W'($urandom_range(0, 16'hFFFF));
                default: begin
                    if (want_occ && thr > 1)
                        r.ranges[i] = RANGE_W'($urandom_range(1, thr - 1));
                    else if (!want_occ)
                        r.ranges[i] = RANGE_W'($urandom_range(thr, 16'hFFFF));
                    else
                        r.ranges[i] = RANGE_W'($urandom_range(0, 16'hFFFF));
                end
            endcase
        end
        return r;
    endfunction

    // offer one round, hold it until accepted, then record its result
    task automatic send_round(input t_round r);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= r.tray_in;
        i_s_tdata  <= {r.ranges, r.read_ok, r.present};
        do @(posedge i_clk); while (!o_s_tready);
        pending_reports.push_back(next_report(r));
    endtask

    // stop offering and wait until every result is back
    task automatic drain_reports();
        i_s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_THR_NORMAL: model_cfg.thr_normal = value;
            REG_THR_FIRST:  model_cfg.thr_first  = value;
            REG_FIRST_POS:  model_cfg.first_pos  = value[0];
            REG_LAYER_EN:   model_cfg.layer_en   = value[0];
            REG_CALIB:      model_cfg.calib      = value[0];
            REG_DEB_LIMIT:  model_cfg.deb_limit  = value[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // write the whole register set once the block is idle
    task automatic load_config(input t_cfg c);
        drain_reports();
        write_reg(REG_THR_NORMAL, c.thr_normal);
        write_reg(REG_THR_FIRST, c.thr_first);
        write_reg(REG_FIRST_POS, CFG_DATA_W'(c.first_pos));
        write_reg(REG_LAYER_EN, CFG_DATA_W'(c.layer_en));
        write_reg(REG_CALIB, CFG_DATA_W'(c.calib));
        write_reg(REG_DEB_LIMIT, CFG_DATA_W'(c.deb_limit));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // compare one accepted result with the oldest pending one
    task automatic check_report();
        t_report got;
        t_report want;
        int      i;
        got.shown           = o_m_tdata[FIELD_SENSORS*RANGE_W-1:0];
        got.least           = o_m_tdata[2*FIELD_SENSORS*RANGE_W-1:FIELD_SENSORS*RANGE_W];
        got.occupied        = o_m_tuser[0];
        got.installed_now   = o_m_tuser[1];
        got.installed_event = o_m_tuser[2];
        got.occupied_event  = o_m_tuser[3];
        if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
                     $time, o_m_tdata, o_m_tuser);
            fail_count++;
        end else begin
            want = pending_reports.pop_front();
            for (i = 0; i < FIELD_SENSORS; i++) begin
                check_field($sformatf("shown[%0d]", i), want.shown[i], got.shown[i]);
                check_field($sformatf("least[%0d]", i), want.least[i], got.least[i]);
            end
            check_field("occupied", want.occupied, got.occupied);
            check_field("installed_now", want.installed_now, got.installed_now);
            check_field("installed_event", want.installed_event, got.installed_event);
            check_field("occupied_event", want.occupied_event, got.occupied_event);
        end
    endtask

    // sample results, then pick the receiver's readiness for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            check_report();
        i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // end the run when no channel moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("tray_presence_debouncer_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // install and removal events, blanking while the layer is down
    task automatic test_tray_and_layer();
        t_cfg c;
        send_round(make_round(1'b1, 4'hF, 4'hF, 100, 100, 100, 100));
        send_round(make_round(1'b0, 4'hF, 4'hF, 100, 100, 100, 100));
        c          = model_cfg;
        c.layer_en = 1'b1;
        c.deb_limit = '0;
        load_config(c);
        send_round(make_round(1'b1, 4'hF, 4'hF, 250, 500, 1000, 2000));
        send_round(make_round(1'b0, 4'hF, 4'hF, 1, 1, 1, 1));
    endtask

    // zero and no-range readings, absent sensors, failed reads
    task automatic test_masks_and_extremes();
        send_round(make_round(1'b1, 4'hF, 4'hF, 0, NO_RANGE, NO_RANGE, 380));
        send_round(make_round(1'b1, 4'h0, 4'hF, 10, 10, 10, 10));
        send_round(make_round(1'b1, 4'hF, 4'h0, 10, 10, 10, 10));
        send_round(make_round(1'b1, 4'hA, 4'h5, 20, 30, 40, 50));
        send_round(make_round(1'b1, 4'h5, 4'h5, 379, 16'hFFFE, 1, 16'h8000));
    endtask

    // first-position select and thresholds at both extremes
    task automatic test_thresholds();
        t_cfg c;
        c           = model_cfg;
        c.first_pos = 1'b1;
        load_config(c);
        send_round(make_round(1'b1, 4'hF, 4'hF, 300, 400, NO_RANGE, NO_RANGE));
        send_round(make_round(1'b1, 4'hF, 4'hF, 299, 400, NO_RANGE, NO_RANGE));
        c.thr_first = '0;
        load_config(c);
        send_round(make_round(1'b1, 4'hF, 4'hF, 1, 2, 3, 4));
        c.thr_first = 16'hFFFF;
        load_config(c);
        send_round(make_round(1'b1, 4'hF, 4'hF, 16'hFFFE, NO_RANGE, NO_RANGE, NO_RANGE));
        c.first_pos  = 1'b0;
        c.thr_normal = 16'hFFFF;
        load_config(c);
        send_round(make_round(1'b1, 4'hF, 4'hF, NO_RANGE, NO_RANGE, NO_RANGE, NO_RANGE));
        c.thr_normal = '0;
        load_config(c);
        send_round(make_round(1'b1, 4'hF, 4'hF, 1, 1, 1, 1));
    endtask

    // calibration freezes everything; a downed layer blanks even close readings
    task automatic test_calibration();
        t_cfg c;
        c            = model_cfg;
        c.thr_normal = THR_NORMAL_RST;
        c.thr_first  = THR_FIRST_RST;
        c.calib      = 1'b1;
        load_config(c);
        send_round(make_round(1'b0, 4'hF, 4'hF, 5, 5, 5, 5));
        send_round(make_round(1'b1, 4'hF, 4'hF, 5, 5, 5, 5));
        c.calib    = 1'b0;
        c.layer_en = 1'b0;
        load_config(c);
        send_round(make_round(1'b1, 4'hF, 4'hF, 5, 5, 5, 5));
    endtask

    // a matching round restarts the count; the flip lands past the limit
    task automatic test_debounce();
        t_cfg c;
        int   k;
        c           = model_cfg;
        c.layer_en  = 1'b1;
        c.deb_limit = LIMIT_W'(2);
        load_config(c);
        for (k = 0; k < 3; k++)
            send_round(make_round(1'b1, 4'hF, 4'hF, 1000, 1000, 1000, 1000));
        send_round(make_round(1'b1, 4'hF, 4'hF, 100, 1000, 1000, 1000));
        send_round(make_round(1'b1, 4'hF, 4'hF, 1000, 100, 1000, 1000));
        send_round(make_round(1'b1, 4'hF, 4'hF, 1000, 1000, 1000, 1000));
        for (k = 0; k < 3; k++)
            send_round(make_round(1'b1, 4'hF, 4'hF, 1000, 1000, 100, 1000));
    endtask

    // random rounds in runs of one occupancy, through several register sets
    task automatic test_random(input int tx_pct, input int rx_pct);
        t_cfg c;
        int   phase;
        int   sent;
        int   run_len;
        int   k;
        logic want_occ;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            c.thr_normal = THR_NORMAL_RST;
            c.thr_first  = THR_FIRST_RST;
            c.first_pos  = 1'b0;
            c.layer_en   = 1'b1;
            c.calib      = 1'b0;
            c.deb_limit  = DEB_LIMIT_RST;
            case (phase)
                1: begin
                    c.first_pos = 1'b1;
                    c.deb_limit = '0;
                end
                2: begin
                    c.thr_normal = 16'hFFFF;
                    c.thr_first  = '0;
                    c.deb_limit  = '1;
                end
                3: begin
                    c.thr_normal = '0;
                    c.thr_first  = 16'hFFFF;
                    c.first_pos  = 1'b1;
                    c.deb_limit  = LIMIT_W'(1);
                end
                4, 5: begin
                    c.thr_normal = RANGE_W'($urandom_range(0, 16'hFFFF));
                    c.thr_first  = RANGE_W'($urandom_range(0, 16'hFFFF));
                    c.first_pos  = 1'($urandom_range(0, 1));
                    c.deb_limit  = LIMIT_W'($urandom_range(0, 15));
                    if (phase == 5) begin
                        c.layer_en = ($urandom_range(0, 3) != 0);
                        c.calib    = ($urandom_range(0, 3) == 0);
                    end
                end
                default: ;
            endcase
            load_config(c);
            sent = 0;
            while (sent < ROUNDS_PER_PHASE) begin
                want_occ = 1'($urandom_range(0, 1));
                run_len  = $urandom_range(1, 24);
                for (k = 0; k < run_len && sent < ROUNDS_PER_PHASE; k++) begin
                    send_round(random_round(want_occ));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        model_cfg.thr_normal = THR_NORMAL_RST;
        model_cfg.thr_first  = THR_FIRST_RST;
        model_cfg.first_pos  = 1'b0;
        model_cfg.layer_en   = 1'b0;
        model_cfg.calib      = 1'b0;
        model_cfg.deb_limit  = DEB_LIMIT_RST;
        stored_dist          = {FIELD_SENSORS{NO_RANGE}};
        least_dist           = {FIELD_SENSORS{NO_RANGE}};
        occ_flag             = 1'b0;
        inst_flag            = 1'b0;
        miss_count           = '0;
        tx_idle_pct          = 11;
        rx_idle_pct          = 58;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_tray_and_layer();
        test_masks_and_extremes();
        test_thresholds();
        test_calibration();
        test_debounce();
        test_random(11, 58);
        test_random(58, 11);
        test_random(0, 0);

        drain_reports();
        if (fail_count == 0)
            $display("tray_presence_debouncer_tb passed");
        else
            $display("tray_presence_debouncer_tb failed");
        $finish;
    end

endmodule
